### hdl/min_tracking_stack_defines.svh
// Assertion macros used by the checker file of the min-tracking stack.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mst_pkg.sv
// Shared widths, codes and types of the min-tracking stack.
`timescale 1ns / 1ps

package mst_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int MODE_W        = 2;
    localparam int WORD_W        = 32;
    localparam int ENTRY_W       = 34;
    localparam int STATUS_W      = 2;
    localparam int COUNT_OUT_W   = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_PEEK = 2'd2,
        MODE_MIN  = 2'd3
    } mst_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } mst_status_t;

    // Shift command broadcast to every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
    } mst_shift_t;

endpackage

### hdl/mst_if.sv
// Command and response channel interfaces of the min-tracking stack.
`timescale 1ns / 1ps

interface mst_cmd_if import mst_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface mst_rsp_if import mst_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] result_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_OUT_W-1:0]   entry_count;

    modport source (output valid, output result_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input result_value, input status, input entry_count,
                    output ready);
endinterface

### hdl/mst_cell.sv
// One storage cell of the shifting stack row.
`timescale 1ns / 1ps

module mst_cell import mst_pkg::*;
(
    input  logic               clk,
    input  mst_shift_t         shift,
    input  logic [ENTRY_W-1:0] upper_word,
    input  logic [ENTRY_W-1:0] lower_word,
    output logic [ENTRY_W-1:0] word
);

    logic [ENTRY_W-1:0] word_reg;

    // Take the word from above on a push, from below on a pop, else hold
    always_ff @(posedge clk)
    begin
        if (shift.push)
        begin
            word_reg <= upper_word;
        end
        else if (shift.pop)
        begin
            word_reg <= lower_word;
        end
    end

    assign word = word_reg;

endmodule

### hdl/mst_ctrl.sv
// Head control: minimum register, fill count, operation decode and response register.
`timescale 1ns / 1ps

module mst_ctrl import mst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    mst_cmd_if.sink            cmd,
    mst_rsp_if.source          rsp,
    input  logic [ENTRY_W-1:0] top_word,
    output mst_shift_t         shift,
    output logic [ENTRY_W-1:0] push_word
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic signed [WORD_W-1:0]   min_reg;
    logic signed [WORD_W-1:0]   min_next;
    logic                       rsp_valid_reg;
    logic signed [WORD_W-1:0]   result_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [COUNT_OUT_W-1:0]     entry_count_reg;

    logic                       take;
    logic                       empty;
    logic                       full;
    logic signed [WORD_W-1:0]   x;
    logic signed [ENTRY_W-1:0]  x_ext;
    logic signed [ENTRY_W-1:0]  min_ext;
    logic signed [ENTRY_W-1:0]  t;
    logic signed [ENTRY_W-1:0]  restore_min;
    logic signed [WORD_W-1:0]   value;
    mst_status_t                status;
    logic                       do_push;
    logic                       do_pop;

    // Accept a beat whenever the response register is free or being drained
    assign take  = cmd.valid && cmd.ready;
    assign cmd.ready = !rsp_valid_reg || rsp.ready;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign x       = cmd.push_value;
    assign x_ext   = {{(ENTRY_W - WORD_W){x[WORD_W-1]}}, x};
    assign min_ext = {{(ENTRY_W - WORD_W){min_reg[WORD_W-1]}}, min_reg};
    assign t       = top_word;

    // Previous minimum from an encoded top word
    assign restore_min = (min_ext <<< 1) - t;

    // Decode the operation against the head cell and the minimum
    always_comb
    begin
        value      = '0;
        status     = STATUS_OK;
        min_next   = min_reg;
        count_next = count_reg;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        push_word  = x_ext;
        case (mst_mode_t'(cmd.mode))
            MODE_PUSH:
            begin
                if (full)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    do_push    = 1'b1;
                    value      = x;
                    count_next = count_reg + CW'(1);
                    if (empty)
                    begin
                        min_next = x;
                    end
                    else if (x_ext < min_ext)
                    begin
                        push_word = (x_ext <<< 1) - min_ext;
                        min_next  = x;
                    end
                end
            end
            MODE_POP, MODE_PEEK, MODE_MIN:
            begin
                if (empty)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    if (mst_mode_t'(cmd.mode) == MODE_MIN)
                    begin
                        value = min_reg;
                    end
                    else if (t < min_ext)
                    begin
                        value = min_reg;
                        if (mst_mode_t'(cmd.mode) == MODE_POP)
                        begin
                            min_next = restore_min[WORD_W-1:0];
                        end
                    end
                    else
                    begin
                        value = t[WORD_W-1:0];
                    end
                    if (mst_mode_t'(cmd.mode) == MODE_POP)
                    begin
                        do_pop     = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                status = STATUS_OK;
            end
        endcase
    end

    assign shift.push = take && do_push;
    assign shift.pop  = take && do_pop;

    // Hold control state: count, minimum and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg <= count_next;
                min_reg   <= min_next;
            end
            if (take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Load the response payload with each accepted beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg      <= value;
            status_reg      <= status;
            entry_count_reg <= COUNT_OUT_W'(count_next);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = result_reg;
    assign rsp.status       = status_reg;
    assign rsp.entry_count  = entry_count_reg;

endmodule

### hdl/min_tracking_stack.sv
// Min-tracking stack top level: head control plus a shifting row of DEPTH cells.
// The response beat is registered and valid in the cycle after its command beat is accepted.
// Throughput: one command per cycle, set by the compares and adds on the head cell
// and the minimum register; a stalled response holds the next command off.
// Reset clears the fill count, the minimum and the response valid; cells hold
// undefined words until pushed, with no clearing pass.
`timescale 1ns / 1ps

module min_tracking_stack import mst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    mst_cmd_if.sink    cmd,
    mst_rsp_if.source  rsp
);

    mst_shift_t         shift;
    logic [ENTRY_W-1:0] push_word;
    logic [ENTRY_W-1:0] cell_word [DEPTH];

    mst_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .top_word  (cell_word[0]),
        .shift     (shift),
        .push_word (push_word)
    );

    // Row of cells: cell 0 is the top of stack, words move down on push, up on pop
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ENTRY_W-1:0] upper;
        logic [ENTRY_W-1:0] lower;

        if (i == 0)
        begin : g_head
            assign upper = push_word;
        end
        else
        begin : g_body
            assign upper = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign lower = cell_word[i];
        end
        else
        begin : g_link
            assign lower = cell_word[i+1];
        end

        mst_cell u_cell (
            .clk        (clk),
            .shift      (shift),
            .upper_word (upper),
            .lower_word (lower),
            .word       (cell_word[i])
        );
    end

endmodule

### hdl/mst_checker.sv
// Port-level checks of the min-tracking stack and their binding to the top level.
`timescale 1ns / 1ps
`include "min_tracking_stack_defines.svh"

module mst_checker import mst_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cmd_valid,
    input logic                     cmd_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic signed [WORD_W-1:0] result_value,
    input logic [STATUS_W-1:0]      status,
    input logic [COUNT_OUT_W-1:0]   entry_count
);

    // Every accepted command beat produces a response beat next cycle
    `MST_ASSERT_NEXT(a_cmd_gives_rsp, clk, rst_n, cmd_valid && cmd_ready, rsp_valid, "accepted command gave no response")

    // An empty-stack report carries zero value and zero count
    `MST_ASSERT_SAME(a_empty_rsp, clk, rst_n, rsp_valid && status == STATUS_EMPTY, result_value == '0 && entry_count == '0, "empty report with nonzero value or count")

    // A dropped push reports zero value
    `MST_ASSERT_SAME(a_full_rsp, clk, rst_n, rsp_valid && status == STATUS_FULL, result_value == '0, "full report with nonzero value")

    // A stalled response beat holds its payload
    `MST_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(result_value) && $stable(status) && $stable(entry_count), "stalled response changed")

endmodule

bind min_tracking_stack mst_checker u_mst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .status       (rsp.status),
    .entry_count  (rsp.entry_count)
);

### dv/tb_min_tracking_stack.sv
// Self-checking testbench of the min-tracking stack: directed table, then random phases.
`timescale 1ns / 1ps

module tb_min_tracking_stack;
    import mst_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEFAULT;
    localparam int RANDOM_OPS  = 1350;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_WAIT    = 10;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_M1  = 32'hFFFF_FFFF;

    // One response beat as the stack reports it
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        mst_status_t              status;
        logic [COUNT_OUT_W-1:0]   count;
    } stack_rsp_t;

    // One row of the directed table; rsp is only used where known is set
    typedef struct packed {
        mst_mode_t                mode;
        logic signed [WORD_W-1:0] push_value;
        logic                     known;
        stack_rsp_t               rsp;
    } op_row_t;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIX,
        PH_DESCEND
    } phase_t;

    localparam int OP_ROWS = 25;
    localparam op_row_t OP_TABLE [OP_ROWS] = '{
        '{MODE_POP,  32'sd0,   1'b1, '{32'sd0,   STATUS_EMPTY, 9'd0}},
        '{MODE_PEEK, 32'sd0,   1'b1, '{32'sd0,   STATUS_EMPTY, 9'd0}},
        '{MODE_MIN,  32'sd0,   1'b1, '{32'sd0,   STATUS_EMPTY, 9'd0}},
        '{MODE_PUSH, 32'sd5,   1'b1, '{32'sd5,   STATUS_OK,    9'd1}},
        '{MODE_MIN,  32'sd0,   1'b1, '{32'sd5,   STATUS_OK,    9'd1}},
        '{MODE_PUSH, WORD_MAX, 1'b1, '{WORD_MAX, STATUS_OK,    9'd2}},
        '{MODE_PEEK, 32'sd0,   1'b1, '{WORD_MAX, STATUS_OK,    9'd2}},
        '{MODE_PUSH, WORD_MIN, 1'b1, '{WORD_MIN, STATUS_OK,    9'd3}},
        '{MODE_PEEK, 32'sd0,   1'b1, '{WORD_MIN, STATUS_OK,    9'd3}},
        '{MODE_MIN,  32'sd0,   1'b1, '{WORD_MIN, STATUS_OK,    9'd3}},
        '{MODE_POP,  32'sd0,   1'b1, '{WORD_MIN, STATUS_OK,    9'd2}},
        '{MODE_MIN,  32'sd0,   1'b1, '{32'sd5,   STATUS_OK,    9'd2}},
        '{MODE_PUSH, WORD_M1,  1'b1, '{WORD_M1,  STATUS_OK,    9'd3}},
        '{MODE_PUSH, WORD_M1,  1'b0, '0},
        '{MODE_POP,  32'sd0,   1'b0, '0},
        '{MODE_POP,  32'sd0,   1'b1, '{WORD_M1,  STATUS_OK,    9'd2}},
        '{MODE_MIN,  32'sd0,   1'b1, '{32'sd5,   STATUS_OK,    9'd2}},
        '{MODE_POP,  32'sd0,   1'b1, '{WORD_MAX, STATUS_OK,    9'd1}},
        '{MODE_POP,  32'sd0,   1'b1, '{32'sd5,   STATUS_OK,    9'd0}},
        '{MODE_MIN,  32'sd0,   1'b1, '{32'sd0,   STATUS_EMPTY, 9'd0}},
        '{MODE_PUSH, 32'sd0,   1'b1, '{32'sd0,   STATUS_OK,    9'd1}},
        '{MODE_PUSH, WORD_MIN, 1'b0, '0},
        '{MODE_POP,  32'sd0,   1'b0, '0},
        '{MODE_MIN,  32'sd0,   1'b0, '0},
        '{MODE_POP,  32'sd0,   1'b1, '{32'sd0,   STATUS_OK,    9'd0}}
    };

    logic clk;
    logic rst_n;

    mst_cmd_if cmd_ch ();
    mst_rsp_if rsp_ch ();

    min_tracking_stack #(.DEPTH(STACK_DEPTH)) i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Predicted stack contents, fill level and minimum
    logic signed [ENTRY_W-1:0] stk_words [STACK_DEPTH];
    int                        stk_fill;
    logic signed [WORD_W-1:0]  stk_min;

    stack_rsp_t expected_rsp_q [$];
    int         fail_count;
    int         ops_sent;
    int         idle_cycles;
    int         snk_wait;
    bit         src_fast;
    bit         snk_fast;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int draw_wait(input bit fast);
        return fast ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Apply one operation to the predicted stack and return the response
    function automatic stack_rsp_t predict_stack_op(input mst_mode_t mode,
                                                    input logic signed [WORD_W-1:0] x);
        stack_rsp_t r;
        longint     top_word;
        longint     wide;
        r        = '0;
        r.status = STATUS_OK;
        if (mode == MODE_PUSH) begin
            if (stk_fill >= STACK_DEPTH) begin
                r.status = STATUS_FULL;
            end
            else begin
                if (stk_fill == 0) begin
                    stk_min             = x;
                    stk_words[stk_fill] = ENTRY_W'(x);
                end
                else if (x < stk_min) begin
                    // store the encoded word so the old minimum can be recovered
                    wide                = 2 * longint'(x) - longint'(stk_min);
                    stk_words[stk_fill] = wide[ENTRY_W-1:0];
                    stk_min             = x;
                end
                else begin
                    stk_words[stk_fill] = ENTRY_W'(x);
                end
                stk_fill++;
                r.value = x;
            end
        end
        else if (stk_fill == 0) begin
            r.status = STATUS_EMPTY;
        end
        else begin
            top_word = longint'(stk_words[stk_fill-1]);
            if (mode == MODE_MIN) begin
                r.value = stk_min;
            end
            else if (top_word < longint'(stk_min)) begin
                // encoded top: the true value is the minimum itself
                r.value = stk_min;
                if (mode == MODE_POP) begin
                    wide    = 2 * longint'(stk_min) - top_word;
                    stk_min = wide[WORD_W-1:0];
                end
            end
            else begin
                r.value = top_word[WORD_W-1:0];
            end
            if (mode == MODE_POP)
                stk_fill--;
        end
        r.count = stk_fill[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        logic signed [WORD_W-1:0] w;
        case ($urandom_range(0, 4))
            0: w = $urandom_range(0, 16) - 8;
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       w = WORD_MAX;
                    1:       w = WORD_MIN;
                    2:       w = 32'sd0;
                    3:       w = WORD_M1;
                    default: w = 32'sd1;
                endcase
            end
            2:       w = WORD_MAX - $urandom_range(0, 15);
            3:       w = WORD_MIN + $urandom_range(0, 15);
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // Drive one command beat; entered and left at a falling edge
    task automatic send_op(input mst_mode_t mode, input logic signed [WORD_W-1:0] x,
                           input logic known, input stack_rsp_t known_rsp);
        int         gap;
        stack_rsp_t pred;
        gap = draw_wait(src_fast);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.mode       <= mode;
        cmd_ch.push_value <= x;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pred = predict_stack_op(mode, x);
        expected_rsp_q.push_back(known ? known_rsp : pred);
        ops_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input mst_mode_t mode, input logic signed [WORD_W-1:0] x);
        send_op(mode, x, 1'b0, '0);
    endtask

    // Hold ready low for the drawn number of cycles after each response beat
    always @(negedge clk)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else if (snk_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            snk_wait--;
        end
        else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Check response beats and watch for a stalled run
    always @(posedge clk)
    begin : rsp_check
        stack_rsp_t want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp_q.size() == 0) begin
                $error("response beat with nothing expected: value %0d status %0d count %0d",
                       rsp_ch.result_value, rsp_ch.status, rsp_ch.entry_count);
                fail_count++;
            end
            else begin
                want = expected_rsp_q.pop_front();
                if (rsp_ch.result_value !== want.value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.value, rsp_ch.result_value);
                    fail_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.count, rsp_ch.entry_count);
                    fail_count++;
                end
            end
            snk_wait = draw_wait(snk_fast);
        end
        if ((rsp_ch.valid && rsp_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        phase_t phase;
        longint v;
        int     k;
        bit     first_phase;

        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.mode       = MODE_PUSH;
        cmd_ch.push_value = '0;
        stk_fill          = 0;
        stk_min           = '0;
        fail_count        = 0;
        ops_sent          = 0;
        idle_cycles       = 0;
        snk_wait          = 0;
        src_fast          = 1'b0;
        snk_fast          = 1'b0;
        first_phase       = 1'b1;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        for (int i = 0; i < OP_ROWS; i++)
            send_op(OP_TABLE[i].mode, OP_TABLE[i].push_value, OP_TABLE[i].known,
                    OP_TABLE[i].rsp);

        // Random phases; the first always fills the stack to overflow
        while (ops_sent < OP_ROWS + RANDOM_OPS) begin
            k = $urandom_range(0, 15);
            if (first_phase || k == 0)
                phase = PH_FILL;
            else if (k <= 3)
                phase = PH_DRAIN;
            else if (k <= 6)
                phase = PH_DESCEND;
            else
                phase = PH_MIX;
            first_phase = 1'b0;
            src_fast    = ($urandom_range(0, 3) == 0);
            snk_fast    = ($urandom_range(0, 3) == 0);

            case (phase)
                PH_FILL:
                begin
                    while (stk_fill < STACK_DEPTH) begin
                        if ($urandom_range(0, 7) == 0)
                            send_random($urandom_range(0, 1) ? MODE_PEEK : MODE_MIN,
                                        rand_word());
                        else
                            send_random(MODE_PUSH, rand_word());
                    end
                    // push onto a full stack
                    repeat ($urandom_range(1, 3))
                        send_random(MODE_PUSH, rand_word());
                end
                PH_DRAIN:
                begin
                    while (stk_fill > 0) begin
                        if ($urandom_range(0, 5) == 0)
                            send_random($urandom_range(0, 1) ? MODE_PEEK : MODE_MIN,
                                        rand_word());
                        else
                            send_random(MODE_POP, rand_word());
                    end
                    // operations on an empty stack
                    repeat ($urandom_range(1, 3))
                        send_random(mst_mode_t'($urandom_range(1, 3)), rand_word());
                end
                PH_DESCEND:
                begin
                    // falling pushes build a chain of encoded words, then unwind it
                    k = $urandom_range(3, 40);
                    v = longint'(rand_word());
                    repeat (k) begin
                        send_random(MODE_PUSH, v[WORD_W-1:0]);
                        v = v - $urandom_range(0, 1 << 20);
                        if (v < longint'(WORD_MIN))
                            v = longint'(WORD_MIN);
                    end
                    repeat (k) begin
                        if ($urandom_range(0, 3) == 0)
                            send_random($urandom_range(0, 1) ? MODE_PEEK : MODE_MIN,
                                        rand_word());
                        send_random(MODE_POP, rand_word());
                    end
                end
                default:
                begin
                    repeat ($urandom_range(20, 60))
                        send_random(mst_mode_t'($urandom_range(0, 3)), rand_word());
                end
            endcase
        end
        cmd_ch.valid <= 1'b0;

        // Let the last responses arrive, then settle
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/mst_pkg.sv
hdl/mst_if.sv
hdl/mst_cell.sv
hdl/mst_ctrl.sv
hdl/min_tracking_stack.sv
hdl/mst_checker.sv
dv/tb_min_tracking_stack.sv
